[sv/svwi_pkg.sv]
package svwi_pkg;
  localparam int unsigned MaxElements = 64;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned AddrWidth   = $clog2(MaxElements);
  localparam int unsigned CountWidth  = $clog2(MaxElements + 1);

  typedef struct packed {
    logic signed [ValueWidth-1:0] sample_value;
    logic                         is_final;
  } in_word_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] sorted_value;
    logic [5:0]                   original_position;
    logic                         last_of_run;
    logic                         overflow_seen;
  } out_word_t;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [AddrWidth-1:0]  position;
  } entry_t;
endpackage

[sv/sort_values_with_index.sv]
// Words are loaded while busy is low; a word is taken when start is high.
// On a final word the set of n elements is insertion sorted in the store,
// one memory read per cycle, bound by the single read and single write port
// of the store.
// Then n results follow, one per cycle; the receiver cannot stall them.
// Reset (rst_ni low, asynchronous) empties the set; the store is not cleared.
module sort_values_with_index (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  svwi_pkg::in_word_t    in_word_i,
  output logic                  busy,
  output logic                  result_valid_o,
  output svwi_pkg::out_word_t   result_o
);
  import svwi_pkg::*;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StFetchI = 7'b0000010,
    StHoldI  = 7'b0000100,
    StScan   = 7'b0001000,
    StCmp    = 7'b0010000,
    StOutRd  = 7'b0100000,
    StOut    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CountWidth-1:0] fill_q, fill_d;
  logic dropped_q, dropped_d;
  logic [CountWidth-1:0] i_q, i_d, j_q, j_d;
  entry_t key_q, key_d;

  logic we;
  logic [AddrWidth-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic valid_d;
  out_word_t res_d;

  svwi_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  function automatic logic key_gt(logic [ValueWidth-1:0] a, logic [ValueWidth-1:0] b);
    return $signed(a) > $signed(b);
  endfunction

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    dropped_d = dropped_q;
    i_d = i_q;
    j_d = j_q;
    key_d = key_q;
    we = 1'b0;
    waddr = '0;
    wdata = key_q;
    raddr = '0;
    valid_d = 1'b0;
    res_d = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          if (fill_q < CountWidth'(MaxElements)) begin
            we = 1'b1;
            waddr = fill_q[AddrWidth-1:0];
            wdata.value = in_word_i.sample_value;
            wdata.position = fill_q[AddrWidth-1:0];
            fill_d = fill_q + 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
          if (in_word_i.is_final) begin
            i_d = CountWidth'(1);
            state_d = StFetchI;
          end
        end
      end
      StFetchI: begin
        // Read element i as the key to insert, or start the output pass.
        if (i_q >= fill_q) begin
          i_d = '0;
          state_d = (fill_q == '0) ? StIdle : StOutRd;
          if (fill_q == '0) dropped_d = 1'b0;
        end else begin
          raddr = i_q[AddrWidth-1:0];
          state_d = StHoldI;
        end
      end
      StHoldI: begin
        key_d = rdata;
        j_d = i_q;
        raddr = AddrWidth'(i_q - 1'b1);
        state_d = StCmp;
      end
      StCmp: begin
        // rdata holds element j-1; shift it up while it exceeds the key.
        if (key_gt(rdata.value, key_q.value)) begin
          we = 1'b1;
          waddr = j_q[AddrWidth-1:0];
          wdata = rdata;
          j_d = j_q - 1'b1;
          if (j_q == CountWidth'(1)) begin
            state_d = StScan;
          end else begin
            raddr = AddrWidth'(j_q - 2'd2);
            state_d = StCmp;
          end
        end else begin
          state_d = StScan;
        end
      end
      StScan: begin
        we = 1'b1;
        waddr = j_q[AddrWidth-1:0];
        wdata = key_q;
        i_d = i_q + 1'b1;
        state_d = StFetchI;
      end
      StOutRd: begin
        raddr = i_q[AddrWidth-1:0];
        state_d = StOut;
      end
      StOut: begin
        valid_d = 1'b1;
        res_d.sorted_value = rdata.value;
        res_d.original_position = 6'(rdata.position);
        res_d.last_of_run = (i_q + 1'b1 == fill_q);
        res_d.overflow_seen = dropped_q;
        i_d = i_q + 1'b1;
        raddr = AddrWidth'(i_q + 1'b1);
        if (i_q + 1'b1 == fill_q) begin
          fill_d = '0;
          dropped_d = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q <= '0;
      dropped_q <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      dropped_q <= dropped_d;
      result_valid_o <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    j_q <= j_d;
    key_q <= key_d;
    result_o <= res_d;
  end

  assign busy = (state_q != StIdle);
endmodule

[sv/svwi_ram.sv]
module svwi_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [svwi_pkg::AddrWidth-1:0] waddr_i,
  input  svwi_pkg::entry_t         wdata_i,
  input  logic [svwi_pkg::AddrWidth-1:0] raddr_i,
  output svwi_pkg::entry_t         rdata_o
);
  import svwi_pkg::*;

  entry_t mem [MaxElements];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

[tb/sv/sort_values_with_index_tb.sv]
module sort_values_with_index_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import svwi_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  in_word_t  in_word_i;
  logic      busy;
  logic      result_valid_o;
  out_word_t result_o;

  sort_values_with_index u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .in_word_i      (in_word_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  in_word_t  pending_words[$];
  out_word_t expected_sorted[$];
  int        errors = 0;
  int        gap_left = 0;
  bit        hold_until_drained = 0;
  bit        word_taken = 0;

  // Set currently being loaded, as the block holds it.
  logic signed [ValueWidth-1:0] set_values[MaxElements];
  logic [5:0]                   set_positions[MaxElements];
  int                           set_fill = 0;
  bit                           set_dropped = 0;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Load one word; on a final word, sort the set stably and queue its results.
  task automatic predict_argsort(input in_word_t w);
    logic signed [ValueWidth-1:0] v;
    logic [5:0]                   p;
    int                           j;
    out_word_t                    r;
    if (set_fill < MaxElements) begin
      set_values[set_fill] = w.sample_value;
      set_positions[set_fill] = set_fill[5:0];
      set_fill++;
    end else begin
      set_dropped = 1;
    end
    if (w.is_final) begin
      for (int i = 1; i < set_fill; i++) begin
        v = set_values[i];
        p = set_positions[i];
        j = i;
        while (j > 0 && set_values[j-1] > v) begin
          set_values[j] = set_values[j-1];
          set_positions[j] = set_positions[j-1];
          j--;
        end
        set_values[j] = v;
        set_positions[j] = p;
      end
      for (int k = 0; k < set_fill; k++) begin
        r.sorted_value = set_values[k];
        r.original_position = set_positions[k];
        r.last_of_run = (k == set_fill - 1);
        r.overflow_seen = set_dropped;
        expected_sorted.push_back(r);
      end
      set_fill = 0;
      set_dropped = 0;
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom_range(0, 7) - 4;
      default: return $urandom;
    endcase
  endfunction

  // A word is accepted at a rising edge with start high and busy low.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      predict_argsort(in_word_i);
      word_taken = 1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
      in_word_i <= '0;
      word_taken = 0;
    end else if (start && !word_taken) begin
      // Word still waiting for the block; hold it.
    end else begin
      if (word_taken) begin
        pending_words.pop_front();
        word_taken = 0;
      end
      if (hold_until_drained && expected_sorted.size() == 0 && set_fill == 0
          && !result_valid_o) begin
        hold_until_drained = 0;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_words.size() > 0 && !hold_until_drained) begin
        in_word_i <= pending_words[0];
        start <= 1'b1;
        gap_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_sorted.size() == 0) begin
        $error("unexpected result word: value %0d position %0d",
               result_o.sorted_value, result_o.original_position);
        errors++;
      end else begin
        want = expected_sorted.pop_front();
        if (result_o.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                 result_o.sorted_value);
          errors++;
        end
        if (result_o.original_position !== want.original_position) begin
          $error("original_position: expected %0d, got %0d",
                 want.original_position, result_o.original_position);
          errors++;
        end
        if (result_o.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                 result_o.last_of_run);
          errors++;
        end
        if (result_o.overflow_seen !== want.overflow_seen) begin
          $error("overflow_seen: expected %0b, got %0b", want.overflow_seen,
                 result_o.overflow_seen);
          errors++;
        end
      end
    end
  end

  task automatic queue_set(input int n, input bit extremes);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.sample_value = extremes ? ((i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000)
                                : pick_value();
      w.is_final = (i == n - 1);
      pending_words.push_back(w);
    end
  endtask

  initial begin
    int n;
    rst_ni = 1'b0;
    // Directed: single element, extremes with ties, equal values, full store,
    // and a set with dropped words whose final word is itself dropped.
    queue_set(1, 0);
    queue_set(4, 1);
    for (int i = 0; i < 3; i++) begin
      pending_words.push_back(in_word_t'{sample_value: 32'sd5, is_final: (i == 2)});
    end
    queue_set(MaxElements, 0);
    queue_set(MaxElements + 3, 0);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_words.size() > 0) @(posedge clk_i);
    hold_until_drained = 1;
    // Random sets, mostly small, a few near or beyond capacity.
    for (int s = 0; s < 10; s++) begin
      case ($urandom_range(0, 19))
        0: n = $urandom_range(MaxElements - 2, MaxElements + 4);
        1: n = 1;
        default: n = $urandom_range(2, 10);
      endcase
      queue_set(n, 0);
    end
    while (pending_words.size() > 0 || start) @(posedge clk_i);
    while (expected_sorted.size() > 0 || set_fill != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
